@@ hw/rtl/pwlr_pkg.sv @@
// Piecewise linear resampler: shared constants, control word types and the
// microcode table.
// No dependencies.
`default_nettype none

package pwlr_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int FRAC_BITS   = 16;

    localparam int DATA_W  = 32;
    localparam int STEP_W  = 31;
    localparam int NUM_W   = DATA_W + FRAC_BITS;          // |dy| << FRAC_BITS
    localparam int PROD_W  = NUM_W + 2;                   // slope * offset, modulo
    localparam int YS_W    = PROD_W - FRAC_BITS + 1;      // y1 + shifted product
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int K_W     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_SETUP,
        OP_DIV,
        OP_SLOPE,
        OP_MUL,
        OP_PREP,
        OP_EMIT,
        OP_UPDATE
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_NO_SEG,
        C_CNT_NZ,
        C_NOT_DONE
    } t_cond;

    typedef logic [2:0] t_pc;

    localparam t_pc PC_IDLE   = 3'd0;
    localparam t_pc PC_CHECK  = 3'd1;
    localparam t_pc PC_DIV    = 3'd2;
    localparam t_pc PC_SLOPE  = 3'd3;
    localparam t_pc PC_MUL    = 3'd4;
    localparam t_pc PC_PREP   = 3'd5;
    localparam t_pc PC_EMIT   = 3'd6;
    localparam t_pc PC_UPDATE = 3'd7;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic in_fire;
        logic seg_ok;
        logic cnt_nz;
        logic emit_done;
    } t_stat;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:   w = '{op: OP_WAIT,   cond: C_NO_INPUT, target: PC_IDLE};
            PC_CHECK:  w = '{op: OP_SETUP,  cond: C_NO_SEG,   target: PC_UPDATE};
            PC_DIV:    w = '{op: OP_DIV,    cond: C_CNT_NZ,   target: PC_DIV};
            PC_SLOPE:  w = '{op: OP_SLOPE,  cond: C_NEXT,     target: PC_MUL};
            PC_MUL:    w = '{op: OP_MUL,    cond: C_CNT_NZ,   target: PC_MUL};
            PC_PREP:   w = '{op: OP_PREP,   cond: C_NEXT,     target: PC_EMIT};
            PC_EMIT:   w = '{op: OP_EMIT,   cond: C_NOT_DONE, target: PC_EMIT};
            PC_UPDATE: w = '{op: OP_UPDATE, cond: C_ALWAYS,   target: PC_IDLE};
            default:   w = '{op: OP_WAIT,   cond: C_ALWAYS,   target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pwlr_seq.sv @@
// Microcode sequencer: step counter, control ROM read, conditional jumps.
// Depends on pwlr_pkg.
`default_nettype none

module pwlr_seq (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  pwlr_pkg::t_stat i_stat,
    output pwlr_pkg::t_op   o_op
);
    import pwlr_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w;
    t_pc    pc_inc;

    assign w      = ucode(r_pc);
    assign pc_inc = r_pc + t_pc'(1);
    assign o_op   = w.op;

    always_comb begin
        unique case (w.cond)
            C_NEXT:     n_pc = pc_inc;
            C_ALWAYS:   n_pc = w.target;
            C_NO_INPUT: n_pc = i_stat.in_fire   ? pc_inc : w.target;
            C_NO_SEG:   n_pc = i_stat.seg_ok    ? pc_inc : w.target;
            C_CNT_NZ:   n_pc = i_stat.cnt_nz    ? w.target : pc_inc;
            C_NOT_DONE: n_pc = i_stat.emit_done ? pc_inc : w.target;
            default:    n_pc = PC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pwlr_dp.sv @@
// Datapath: point registers, restoring divider, shift-add multiplier,
// sample generator and output register.
// Depends on pwlr_pkg.
`default_nettype none

module pwlr_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  pwlr_pkg::t_op                      i_op,
    input  wire [pwlr_pkg::STEP_W-1:0]         i_step,
    output pwlr_pkg::t_stat                    o_stat,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [2*pwlr_pkg::DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [2*pwlr_pkg::DATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import pwlr_pkg::*;

    logic [DATA_W-1:0] r_x1, r_y1, r_x2, r_y2, r_dx, r_rem, r_off;
    logic              r_have, r_neg, r_mvalid, r_mlast, r_muser;
    logic [NUM_W-1:0]  r_quo;
    logic [PROD_W-1:0] r_mcand, r_acc, r_inc;
    logic [STEP_W-1:0] r_mplier;
    logic [CNT_W-1:0]  r_cnt;
    logic [K_W-1:0]    r_k;
    logic [DATA_W-1:0] r_mx, r_my;

    logic              in_fire, seg_ok, emit_fire, reach, k_last, last, y_ok;
    logic [DATA_W:0]   dy, dy_abs, trial, diff, off_nxt;
    logic [STEP_W-1:0] step_eff;
    logic [PROD_W-1:0] quo_ext, slope;
    logic [YS_W-1:0]   ysum;
    logic [DATA_W-1:0] y_sat, x_cur;

    assign s_tready = (i_op == OP_WAIT);
    assign in_fire  = s_tvalid && s_tready;
    assign seg_ok   = r_have && ($signed(r_x2) > $signed(r_x1));
    assign step_eff = (i_step == '0) ? STEP_W'(1) : i_step;

    assign dy     = {r_y2[DATA_W-1], r_y2} - {r_y1[DATA_W-1], r_y1};
    assign dy_abs = dy[DATA_W] ? (~dy + 1'b1) : dy;

    assign trial  = {r_rem, r_quo[NUM_W-1]};
    assign diff   = trial - {1'b0, r_dx};

    assign quo_ext = {{(PROD_W-NUM_W){1'b0}}, r_quo};
    assign slope   = r_neg ? (~quo_ext + 1'b1) : quo_ext;

    // sample stage
    assign off_nxt   = {1'b0, r_off} + {{(DATA_W+1-STEP_W){1'b0}}, step_eff};
    assign reach     = off_nxt >= {1'b0, r_dx};
    assign k_last    = (r_k == K_W'(MAX_SAMPLES-1));
    assign last      = reach || k_last;
    assign emit_fire = (i_op == OP_EMIT) && (!r_mvalid || m_tready);
    assign x_cur     = r_x1 + r_off;
    assign ysum      = {{(YS_W-DATA_W){r_y1[DATA_W-1]}}, r_y1}
                     + {r_acc[PROD_W-1], r_acc[PROD_W-1:FRAC_BITS]};
    assign y_ok      = (ysum[YS_W-1:DATA_W-1] == {(YS_W-DATA_W+1){ysum[DATA_W-1]}});
    assign y_sat     = y_ok ? ysum[DATA_W-1:0]
                     : (ysum[YS_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}});

    assign o_stat = '{in_fire: in_fire, seg_ok: seg_ok, cnt_nz: (r_cnt != '0),
                      emit_done: emit_fire && last};

    assign m_tvalid = r_mvalid;
    assign m_tdata  = {r_my, r_mx};
    assign m_tlast  = r_mlast;
    assign m_tuser  = r_muser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_mvalid <= 1'b0;
            r_x1     <= '0;
            r_y1     <= '0;
        end else begin
            if (emit_fire) begin
                r_mvalid <= 1'b1;
            end else if (m_tready) begin
                r_mvalid <= 1'b0;
            end
            if (i_op == OP_UPDATE) begin
                r_x1   <= r_x2;
                r_y1   <= r_y2;
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_WAIT: begin
                if (in_fire) begin
                    r_x2 <= s_tdata[DATA_W-1:0];
                    r_y2 <= s_tdata[2*DATA_W-1:DATA_W];
                end
            end
            OP_SETUP: begin
                r_dx  <= r_x2 - r_x1;
                r_neg <= dy[DATA_W];
                r_quo <= {dy_abs[DATA_W-1:0], {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_cnt <= CNT_W'(NUM_W-1);
            end
            OP_DIV: begin
                r_rem <= diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], ~diff[DATA_W]};
                r_cnt <= r_cnt - 1'b1;
            end
            OP_SLOPE: begin
                r_mcand  <= slope;
                r_mplier <= step_eff;
                r_acc    <= '0;
                r_cnt    <= CNT_W'(STEP_W-1);
            end
            OP_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[STEP_W-1:1]};
                r_cnt    <= r_cnt - 1'b1;
            end
            OP_PREP: begin
                r_inc <= r_acc;
                r_acc <= '0;
                r_off <= '0;
                r_k   <= '0;
            end
            OP_EMIT: begin
                if (emit_fire) begin
                    r_mx    <= x_cur;
                    r_my    <= y_sat;
                    r_mlast <= last;
                    r_muser <= k_last && !reach;
                    r_acc   <= r_acc + r_inc;
                    r_off   <= off_nxt[DATA_W-1:0];
                    r_k     <= r_k + 1'b1;
                end
            end
            OP_UPDATE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/piecewise_linear_resampler_top.sv @@
// Piecewise linear resampler top level: step register, sequencer, datapath.
// Depends on pwlr_pkg, pwlr_seq, pwlr_dp.
//
//  channel  dir  signals                              payload
//  s_       in   s_tvalid s_tready s_tdata[63:0]       point_x, point_y
//  m_       out  m_tvalid m_tready m_tdata m_tlast     sample_x, sample_y,
//                m_tuser                              last_of_run, truncated
//  cfg      in   i_cfg_we i_cfg_wdata[30:0]            sample_step
//
// A point that closes a segment passes through the one-bit-per-cycle divider
// and the shift-add multiplier, then gives one sample per cycle from the output
// register while the m_ side is not stalled. Other points go to the update step.
// Reset is synchronous, active low; no clearing pass. A stalled m_ side
// holds the sequencer in its sample step; the last sample may wait while
// the next point is taken.
`default_nettype none

module piecewise_linear_resampler_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [pwlr_pkg::STEP_W-1:0]         i_cfg_wdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [2*pwlr_pkg::DATA_W-1:0]       s_tdata,  // point_x, point_y
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [2*pwlr_pkg::DATA_W-1:0]      m_tdata,  // sample_x, sample_y
    output logic                               m_tlast,
    output logic                               m_tuser   // truncated
);
    import pwlr_pkg::*;

    logic [STEP_W-1:0] r_step;
    t_op               op;
    t_stat             stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            r_step <= i_cfg_wdata;
        end
    end

    pwlr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_op    (op)
    );

    pwlr_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_step   (r_step),
        .o_stat   (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ hw/rtl/pwlr_checker.sv @@
// Port-level checks for the resampler top level, attached by bind.
// Depends on pwlr_pkg and piecewise_linear_resampler_top.
`default_nettype none

module pwlr_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_cfg_we,
    input wire [pwlr_pkg::STEP_W-1:0]         i_cfg_wdata,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire [2*pwlr_pkg::DATA_W-1:0]       s_tdata,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [2*pwlr_pkg::DATA_W-1:0]       m_tdata,
    input wire                                m_tlast,
    input wire                                m_tuser
);
    import pwlr_pkg::*;

    // truncated only ever marks the final sample
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (!m_tuser || m_tlast))
        else $error("truncated flag without last_of_run");

    // one point in flight: a transaction closes the input for the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");

    // no sample out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_tvalid)
        else $error("result valid straight after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind piecewise_linear_resampler_top pwlr_checker u_pwlr_checker (.*);

`default_nettype wire
